### rtl/core/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and codes for the partition fit allocator: opcodes, placement
// policies, configuration register indexes, controller states and the
// control and status groups passed between the controller and the cells.
// ----------------------------------------------------------------------------
package pfa_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } t_policy;

    localparam logic [3:0] CFG_POLICY      = 4'd0;
    localparam logic [3:0] CFG_BLOCK_COUNT = 4'd1;

    localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // per-cell update strobes, asserted in the commit cycle
    typedef struct packed {
        logic load;
        logic take;
        logic clear;
    } t_cell_ctrl;

    // candidate flags carried along the chain
    typedef struct packed {
        logic main_v;
        logic hi_v;
    } t_scan_flags;

endpackage

### rtl/core/pfa_cell.sv
// ----------------------------------------------------------------------------
// pfa_cell
// One partition block: holds its size and taken flag, and refines the
// candidate that passes through it on the way to the next cell.
// ----------------------------------------------------------------------------
module pfa_cell #(
    parameter int CELL_IDX  = 0,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5,
    parameter int SIZE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfa_pkg::t_cell_ctrl   i_ctrl,
    input  logic [SIZE_BITS-1:0]  i_load_size,
    input  logic [SIZE_BITS-1:0]  i_req,
    input  logic [CNT_W-1:0]      i_cnt,
    input  logic [IDX_W-1:0]      i_start,
    input  pfa_pkg::t_policy      i_policy,
    input  pfa_pkg::t_scan_flags  i_flags,
    input  logic [IDX_W-1:0]      i_main_idx,
    input  logic [SIZE_BITS-1:0]  i_main_left,
    input  logic [IDX_W-1:0]      i_hi_idx,
    input  logic [SIZE_BITS-1:0]  i_hi_left,
    output pfa_pkg::t_scan_flags  o_flags,
    output logic [IDX_W-1:0]      o_main_idx,
    output logic [SIZE_BITS-1:0]  o_main_left,
    output logic [IDX_W-1:0]      o_hi_idx,
    output logic [SIZE_BITS-1:0]  o_hi_left
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_taken;
    pfa_pkg::t_scan_flags r_flags;
    logic [IDX_W-1:0]     r_main_idx;
    logic [SIZE_BITS-1:0] r_main_left;
    logic [IDX_W-1:0]     r_hi_idx;
    logic [SIZE_BITS-1:0] r_hi_left;

    logic                 fits;
    logic [SIZE_BITS-1:0] left;
    logic                 take_main;
    logic                 take_hi;

    always_comb begin
        fits = (int'(i_cnt) > CELL_IDX) && !r_taken && (r_size >= i_req);
        left = r_size - i_req;
        unique case (i_policy)
            pfa_pkg::POL_FIRST,
            pfa_pkg::POL_NEXT: begin
                take_main = fits && !i_flags.main_v;
            end
            pfa_pkg::POL_BEST: begin
                take_main = fits && (!i_flags.main_v || (left < i_main_left));
            end
            pfa_pkg::POL_WORST: begin
                take_main = fits && (!i_flags.main_v || (left > i_main_left));
            end
            default: begin
                take_main = 1'b0;
            end
        endcase
        // first fit at or after the roving pointer
        take_hi = fits && !i_flags.hi_v && (CELL_IDX >= int'(i_start));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_taken <= 1'b0;
        end else if (i_ctrl.take) begin
            r_taken <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_size <= i_load_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags.main_v <= i_flags.main_v || take_main;
        r_flags.hi_v   <= i_flags.hi_v || take_hi;
        r_main_idx     <= take_main ? MY_IDX : i_main_idx;
        r_main_left    <= take_main ? left : i_main_left;
        r_hi_idx       <= take_hi ? MY_IDX : i_hi_idx;
        r_hi_left      <= take_hi ? left : i_hi_left;
    end

    assign o_flags     = r_flags;
    assign o_main_idx  = r_main_idx;
    assign o_main_left = r_main_left;
    assign o_hi_idx    = r_hi_idx;
    assign o_hi_left   = r_hi_left;

endmodule

### rtl/core/partition_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator_top
// Fixed-partition allocator with first, next, best and worst fit placement.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in channel (valid/ready) as opcode, block index and
//   size. Load writes a block size, allocate searches for a free block that
//   fits, clear frees all blocks and zeroes the totals. Each request yields
//   exactly one result on the out channel (valid/ready) carrying the grant,
//   the block, the leftover and both fragmentation totals after the request.
//   Policy and block count are to be written on the cfg channel only while idle; the block does not enforce this.
// Timing:
//   An allocate walks the chain of MAX_BLOCKS cells, one cell per cycle, then
//   commits; load, clear and no-op requests go straight to the commit. A
//   new request is accepted only once the previous one has committed.
//   The result sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls, the following request holds in
//   its commit cycle until the output register frees up.
// Reset:
//   Synchronous, active low. Frees every block, zeroes totals and pointer,
//   sets policy to first fit and block count to 16. Block sizes are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module partition_fit_allocator_top #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_block_index,
    input  logic [15:0] i_size_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_granted,
    output logic [3:0]  o_granted_block,
    output logic [15:0] o_leftover,
    output logic [31:0] o_internal_total,
    output logic [31:0] o_external_total
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    // configuration
    pfa_pkg::t_policy r_policy;
    logic [4:0]       r_block_count;

    // request
    pfa_pkg::t_opcode     r_op;
    logic [3:0]           r_idx;
    logic [SIZE_BITS-1:0] r_req;

    // controller
    pfa_pkg::t_state r_state;
    pfa_pkg::t_state n_state;
    logic [IDX_W-1:0] r_scan_cnt;
    logic             in_ready;
    logic             commit_go;

    // persistent state
    logic [IDX_W-1:0] r_rover;
    logic [IDX_W-1:0] n_rover;
    logic [31:0]      r_int_sum;
    logic [31:0]      n_int_sum;
    logic [31:0]      r_ext_sum;
    logic [31:0]      n_ext_sum;

    // result register
    logic        r_out_valid;
    logic        r_granted;
    logic [3:0]  r_gblock;
    logic [15:0] r_leftover;

    // chain
    pfa_pkg::t_scan_flags w_flags     [MAX_BLOCKS+1];
    logic [IDX_W-1:0]     w_main_idx  [MAX_BLOCKS+1];
    logic [SIZE_BITS-1:0] w_main_left [MAX_BLOCKS+1];
    logic [IDX_W-1:0]     w_hi_idx    [MAX_BLOCKS+1];
    logic [SIZE_BITS-1:0] w_hi_left   [MAX_BLOCKS+1];
    pfa_pkg::t_cell_ctrl  cell_ctrl   [MAX_BLOCKS];

    logic [CNT_W-1:0]     used_cnt;
    logic [IDX_W-1:0]     start_idx;
    logic                 is_alloc;
    logic                 grant;
    logic [IDX_W-1:0]     pick_idx;
    logic [SIZE_BITS-1:0] pick_left;
    logic [CNT_W-1:0]     pick_next;
    logic [32:0]          int_add;
    logic [32:0]          ext_add;

    // ------------------------------------------------------------------------
    // configuration port

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy      <= pfa_pkg::POL_FIRST;
            r_block_count <= pfa_pkg::BLOCK_COUNT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == pfa_pkg::CFG_POLICY) begin
                r_policy <= pfa_pkg::t_policy'(i_cfg_data[1:0]);
            end else if (i_cfg_index == pfa_pkg::CFG_BLOCK_COUNT) begin
                r_block_count <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (CMP_W'(r_block_count) > CMP_W'(MAX_BLOCKS)) begin
            used_cnt = CNT_W'(MAX_BLOCKS);
        end else begin
            used_cnt = CNT_W'(r_block_count);
        end
        start_idx = (CNT_W'(r_rover) < used_cnt) ? r_rover : '0;
    end

    // ------------------------------------------------------------------------
    // controller

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (pfa_pkg::t_opcode'(i_opcode) == pfa_pkg::OP_ALLOC) ?
                              pfa_pkg::ST_SCAN : pfa_pkg::ST_COMMIT;
                end
            end
            pfa_pkg::ST_SCAN: begin
                if (r_scan_cnt == IDX_W'(MAX_BLOCKS - 1)) begin
                    n_state = pfa_pkg::ST_COMMIT;
                end
            end
            pfa_pkg::ST_COMMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = (r_state == pfa_pkg::ST_IDLE);
        commit_go = (r_state == pfa_pkg::ST_COMMIT) && (!r_out_valid || i_out_ready);
    end

    assign o_in_ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pfa_pkg::ST_IDLE;
            r_scan_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == pfa_pkg::ST_SCAN) begin
                r_scan_cnt <= r_scan_cnt + IDX_W'(1);
            end else begin
                r_scan_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && in_ready) begin
            r_op  <= pfa_pkg::t_opcode'(i_opcode);
            r_idx <= i_block_index;
            r_req <= SIZE_BITS'(i_size_value);
        end
    end

    // ------------------------------------------------------------------------
    // cell chain

    assign w_flags[0]     = '0;
    assign w_main_idx[0]  = '0;
    assign w_main_left[0] = '0;
    assign w_hi_idx[0]    = '0;
    assign w_hi_left[0]   = '0;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        always_comb begin
            cell_ctrl[g].load  = commit_go && (r_op == pfa_pkg::OP_LOAD) &&
                                 (int'(r_idx) == g);
            cell_ctrl[g].take  = commit_go && grant && (int'(pick_idx) == g);
            cell_ctrl[g].clear = commit_go && (r_op == pfa_pkg::OP_CLEAR);
        end

        pfa_cell #(
            .CELL_IDX  (g),
            .IDX_W     (IDX_W),
            .CNT_W     (CNT_W),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (cell_ctrl[g]),
            .i_load_size (r_req),
            .i_req       (r_req),
            .i_cnt       (used_cnt),
            .i_start     (start_idx),
            .i_policy    (r_policy),
            .i_flags     (w_flags[g]),
            .i_main_idx  (w_main_idx[g]),
            .i_main_left (w_main_left[g]),
            .i_hi_idx    (w_hi_idx[g]),
            .i_hi_left   (w_hi_left[g]),
            .o_flags     (w_flags[g+1]),
            .o_main_idx  (w_main_idx[g+1]),
            .o_main_left (w_main_left[g+1]),
            .o_hi_idx    (w_hi_idx[g+1]),
            .o_hi_left   (w_hi_left[g+1])
        );
    end

    // ------------------------------------------------------------------------
    // commit

    always_comb begin
        is_alloc = (r_op == pfa_pkg::OP_ALLOC);
        // next fit wraps to the lowest fitting block when none lies past the pointer
        if ((r_policy == pfa_pkg::POL_NEXT) && w_flags[MAX_BLOCKS].hi_v) begin
            grant     = is_alloc;
            pick_idx  = w_hi_idx[MAX_BLOCKS];
            pick_left = w_hi_left[MAX_BLOCKS];
        end else begin
            grant     = is_alloc && w_flags[MAX_BLOCKS].main_v;
            pick_idx  = w_main_idx[MAX_BLOCKS];
            pick_left = w_main_left[MAX_BLOCKS];
        end
        pick_next = CNT_W'(pick_idx) + CNT_W'(1);

        int_add = {1'b0, r_int_sum} + 33'(pick_left);
        ext_add = {1'b0, r_ext_sum} + 33'(r_req);

        n_rover   = r_rover;
        n_int_sum = r_int_sum;
        n_ext_sum = r_ext_sum;
        if (r_op == pfa_pkg::OP_CLEAR) begin
            n_rover   = '0;
            n_int_sum = '0;
            n_ext_sum = '0;
        end else if (grant) begin
            n_int_sum = int_add[32] ? '1 : int_add[31:0];
            if (r_policy == pfa_pkg::POL_NEXT) begin
                n_rover = (pick_next >= used_cnt) ? '0 : IDX_W'(pick_next);
            end
        end else if (is_alloc) begin
            n_ext_sum = ext_add[32] ? '1 : ext_add[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover   <= '0;
            r_int_sum <= '0;
            r_ext_sum <= '0;
        end else if (commit_go) begin
            r_rover   <= n_rover;
            r_int_sum <= n_int_sum;
            r_ext_sum <= n_ext_sum;
        end
    end

    // ------------------------------------------------------------------------
    // result register

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_go) begin
            r_granted  <= grant;
            r_gblock   <= grant ? 4'(pick_idx) : 4'd0;
            r_leftover <= grant ? 16'(pick_left) : 16'd0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted        = r_granted;
    assign o_granted_block  = r_gblock;
    assign o_leftover       = r_leftover;
    assign o_internal_total = r_int_sum;
    assign o_external_total = r_ext_sum;

endmodule

### test/partition_fit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_fit_checker
// Watches the register, request and result channels of the partition fit
// allocator. Keeps its own block table, taken flags, roving pointer and
// totals, works out the result of every accepted request and compares each
// accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module partition_fit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_block_index,
    input  logic [15:0] i_size_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_granted,
    input  logic [3:0]  i_granted_block,
    input  logic [15:0] i_leftover,
    input  logic [31:0] i_internal_total,
    input  logic [31:0] i_external_total,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        granted;
        logic [3:0]  blk;
        logic [15:0] leftover;
        logic [31:0] internal_total;
        logic [31:0] external_total;
    } t_placement;

    logic [15:0]      size_tab [16];
    logic             taken [16];
    logic [3:0]       rover;
    logic [31:0]      internal_sum;
    logic [31:0]      external_sum;
    pfa_pkg::t_policy policy;
    logic [4:0]       block_count;
    t_placement       placement_q [$];
    int               fail_count;
    int               result_count;

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // applies one request to the shadow state and returns the result it owes
    function automatic t_placement place_request(input pfa_pkg::t_opcode op,
                                                 input logic [3:0] idx,
                                                 input logic [15:0] sz);
        t_placement  r;
        int          cnt;
        int          pos;
        int          pick;
        int          k;
        logic [15:0] slack;
        logic [15:0] best_slack;
        r          = '0;
        pick       = -1;
        best_slack = '0;
        cnt        = (block_count > 5'd16) ? 16 : int'(block_count);
        case (op)
            pfa_pkg::OP_LOAD: begin
                size_tab[idx] = sz;
            end
            pfa_pkg::OP_ALLOC: begin
                if (policy == pfa_pkg::POL_NEXT) begin
                    pos = (int'(rover) < cnt) ? int'(rover) : 0;
                    for (k = 0; k < cnt; k++) begin
                        if (pick < 0 && !taken[pos] && size_tab[pos] >= sz)
                            pick = pos;
                        pos = (pos + 1 >= cnt) ? 0 : pos + 1;
                    end
                end else begin
                    for (k = 0; k < cnt; k++) begin
                        if (!taken[k] && size_tab[k] >= sz) begin
                            slack = size_tab[k] - sz;
                            // first fit keeps the lowest index, ties keep the lower one
                            if (pick < 0 ||
                                (policy == pfa_pkg::POL_BEST && slack < best_slack) ||
                                (policy == pfa_pkg::POL_WORST && slack > best_slack)) begin
                                pick       = k;
                                best_slack = slack;
                            end
                        end
                    end
                end
                if (pick >= 0) begin
                    taken[pick]  = 1'b1;
                    r.granted    = 1'b1;
                    r.blk        = pick[3:0];
                    r.leftover   = size_tab[pick] - sz;
                    internal_sum = sat_sum(internal_sum, {16'h0000, r.leftover});
                    if (policy == pfa_pkg::POL_NEXT) begin
                        pos   = (pick + 1 >= cnt) ? 0 : pick + 1;
                        rover = pos[3:0];
                    end
                end else begin
                    external_sum = sat_sum(external_sum, {16'h0000, sz});
                end
            end
            pfa_pkg::OP_CLEAR: begin
                for (k = 0; k < 16; k++)
                    taken[k] = 1'b0;
                internal_sum = '0;
                external_sum = '0;
                rover        = '0;
            end
            default: begin
            end
        endcase
        r.internal_total = internal_sum;
        r.external_total = external_sum;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_placement want;
        t_placement got;
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++)
                taken[k] = 1'b0;
            rover        = '0;
            internal_sum = '0;
            external_sum = '0;
            policy       = pfa_pkg::POL_FIRST;
            block_count  = pfa_pkg::BLOCK_COUNT_RESET;
            placement_q.delete();
            fail_count   = 0;
            result_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    pfa_pkg::CFG_POLICY:      policy = pfa_pkg::t_policy'(i_cfg_data[1:0]);
                    pfa_pkg::CFG_BLOCK_COUNT: block_count = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // results first: a result in the same cycle as a request is never its own
            if (i_out_valid && i_out_ready) begin
                got = {i_granted, i_granted_block, i_leftover, i_internal_total,
                       i_external_total};
                result_count++;
                if (placement_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d arrived with nothing expected", result_count);
                end else begin
                    want = placement_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result %0d (exp/got): granted %0d/%0d block %0d/%0d",
                                     result_count, want.granted, got.granted, want.blk,
                                     got.blk);
                            $display("  leftover %0d/%0d internal %0d/%0d external %0d/%0d",
                                     want.leftover, got.leftover,
                                     want.internal_total, got.internal_total,
                                     want.external_total, got.external_total);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                placement_q.push_back(place_request(pfa_pkg::t_opcode'(i_opcode),
                                                    i_block_index, i_size_value));
        end
        o_fail_count <= fail_count;
        o_pending    <= placement_q.size();
    end

endmodule

### test/partition_fit_allocator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_fit_allocator_top_test
// Drives loads, allocates, clears and no-ops into the allocator under every
// placement policy and a range of block counts, with random gaps and stalls
// on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module partition_fit_allocator_top_test;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [4:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [3:0]  block_index;
    logic [15:0] size_value;
    logic        out_valid;
    logic        out_ready;
    logic        granted;
    logic [3:0]  granted_block;
    logic [15:0] leftover;
    logic [31:0] internal_total;
    logic [31:0] external_total;
    int          fail_count;
    int          pending;

    int          tx_max_gap    = 9;
    int          rx_max_stall  = 9;
    int          blocks_in_use = 16;
    int          idle_cycles;
    logic [15:0] shape_size [16];
    logic [15:0] preset_sizes [16] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                                       16'h0100, 16'h0100, 16'h0080, 16'h0200,
                                       16'h0300, 16'h0010, 16'h0400, 16'h7FFF,
                                       16'h8000, 16'h0001, 16'h0FFF, 16'h0100};

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    partition_fit_allocator_top i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_block_index    (block_index),
        .i_size_value     (size_value),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_granted        (granted),
        .o_granted_block  (granted_block),
        .o_leftover       (leftover),
        .o_internal_total (internal_total),
        .o_external_total (external_total)
    );

    partition_fit_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_block_index    (block_index),
        .i_size_value     (size_value),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_granted        (granted),
        .i_granted_block  (granted_block),
        .i_leftover       (leftover),
        .i_internal_total (internal_total),
        .i_external_total (external_total),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // cycles with no handshake on any channel
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                     (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random stall before taking each result
    initial begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = $urandom_range(0, rx_max_stall);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // called and returning at a falling edge
    task automatic send_req(input pfa_pkg::t_opcode op, input logic [3:0] idx,
                            input logic [15:0] sz);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode      = op;
        block_index = idx;
        size_value  = sz;
        in_valid    = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (op == pfa_pkg::OP_LOAD)
            shape_size[idx] = sz;
    endtask

    task automatic write_reg(input logic [3:0] index, input logic [4:0] data);
        cfg_index = index;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // hold off until every owed result has come back
    task automatic settle();
        in_valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [15:0] block_size();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:          v = 16'h0000;
            1:          v = 16'hFFFF;
            2, 3, 4, 5: v = 16'($urandom_range(0, 31) * 8);  // coarse grid gives ties
            default:    v = 16'($urandom);
        endcase
        return v;
    endfunction

    // mostly near a loaded size so that fits, exact fits and misses all happen
    function automatic logic [15:0] request_size();
        logic [15:0] base;
        logic [15:0] v;
        logic [15:0] take;
        base = shape_size[$urandom_range(0, 15)];
        take = 16'($urandom_range(0, 20));
        case ($urandom_range(0, 7))
            0, 1, 2: v = (base > take) ? base - take : 16'h0000;
            3:       v = base + 16'd1;
            4:       v = 16'h0000;
            5:       v = 16'($urandom_range(0, 255));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic run_phase(input int quota);
        int               sent;
        int               n;
        int               kind;
        int               cnt;
        pfa_pkg::t_opcode op;
        cnt  = (blocks_in_use > 16) ? 16 : blocks_in_use;
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                // mostly clear first, refill a few blocks, then allocate past the point of running out
                if ($urandom_range(0, 4) != 0) begin
                    send_req(pfa_pkg::OP_CLEAR, 4'($urandom), 16'($urandom));
                    sent++;
                end
                n = $urandom_range(0, 4);
                repeat (n) begin
                    send_req(pfa_pkg::OP_LOAD, 4'($urandom), block_size());
                    sent++;
                end
                n = $urandom_range(1, cnt + 2);
                repeat (n) begin
                    send_req(pfa_pkg::OP_ALLOC, 4'($urandom), request_size());
                    sent++;
                end
            end else if (kind == 7) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    op = pfa_pkg::t_opcode'($urandom_range(0, 3));
                    send_req(op, 4'($urandom), 16'($urandom));
                    if (op != pfa_pkg::OP_NOP)
                        sent++;
                end
            end else begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    send_req(pfa_pkg::OP_ALLOC, 4'($urandom), request_size());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        pfa_pkg::t_policy pol;
        logic [4:0]       bc;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        opcode      = '0;
        block_index = '0;
        size_value  = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset policy is first fit over all sixteen blocks
        for (int k = 0; k < 16; k++)
            send_req(pfa_pkg::OP_LOAD, k[3:0], preset_sizes[k]);
        send_req(pfa_pkg::OP_ALLOC, 4'h0, 16'h0000);
        send_req(pfa_pkg::OP_ALLOC, 4'hF, 16'hFFFF);
        send_req(pfa_pkg::OP_ALLOC, 4'h5, 16'hFFFF);
        send_req(pfa_pkg::OP_LOAD, 4'h0, 16'h1234);  // reload of a taken block keeps it taken
        send_req(pfa_pkg::OP_ALLOC, 4'hA, 16'h1000);
        send_req(pfa_pkg::OP_NOP, 4'hF, 16'hFFFF);
        send_req(pfa_pkg::OP_CLEAR, 4'h0, 16'h0000);
        send_req(pfa_pkg::OP_ALLOC, 4'h3, 16'h1200);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin pol = pfa_pkg::POL_FIRST; bc = 5'd16; end
                1: begin pol = pfa_pkg::POL_NEXT;  bc = 5'd16; end
                2: begin pol = pfa_pkg::POL_NEXT;  bc = 5'd3;  end
                3: begin pol = pfa_pkg::POL_BEST;  bc = 5'd31; end
                4: begin pol = pfa_pkg::POL_WORST; bc = 5'd0;  end
                5: begin pol = pfa_pkg::POL_BEST;  bc = 5'd1;  end
                6: begin pol = pfa_pkg::POL_WORST; bc = 5'd16; end
                default: begin
                    pol = pfa_pkg::t_policy'($urandom_range(0, 3));
                    bc  = 5'($urandom_range(0, 31));
                end
            endcase
            write_reg(pfa_pkg::CFG_POLICY, {3'b000, pol});
            write_reg(pfa_pkg::CFG_BLOCK_COUNT, bc);
            blocks_in_use = int'(bc);
            case (ph % 4)
                3:       begin tx_max_gap = 0; rx_max_stall = 0; end
                2:       begin tx_max_gap = 0; rx_max_stall = 9; end
                default: begin tx_max_gap = 9; rx_max_stall = 9; end
            endcase
            run_phase(PHASE_ITEMS);
            if (ph == 1) begin
                // park the roving pointer at 8 before the block count drops to 3
                send_req(pfa_pkg::OP_CLEAR, 4'h0, 16'h0000);
                repeat (8) send_req(pfa_pkg::OP_ALLOC, 4'($urandom), 16'h0000);
            end
        end

        in_valid = 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
